// ----- rtl/three_sat_random_walk_step_core_assert.svh -----
// assertion macros used by the step core rtl file
`ifndef THREE_SAT_RANDOM_WALK_STEP_CORE_ASSERT_SVH
`define THREE_SAT_RANDOM_WALK_STEP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define T3SW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication
`define T3SW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define T3SW_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define T3SW_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- rtl/t3sw_pkg.sv -----
package t3sw_pkg;

    localparam int MAX_VARS_DEF    = 64;
    localparam int MAX_CLAUSES_DEF = 256;
    localparam int CLAUSE_W        = 24;
    localparam int ASG_W           = 64;

    // opcodes carried on tuser
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_STEP = 2'd2;

    // configuration register indexes
    localparam logic CFG_VAR_COUNT    = 1'b0;
    localparam logic CFG_CLAUSE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DIV,
        ST_PICK,
        ST_FLIP,
        ST_OUT
    } t_state;

    // literal k of a clause is true under the assignment
    function automatic logic lit_true(input logic [CLAUSE_W-1:0] clause,
                                      input logic [1:0] k,
                                      input logic [ASG_W-1:0] asg,
                                      input int max_vars);
        logic [7:0] lit;
        logic       ok;
        lit = clause[8*k +: 8];
        ok  = !lit[6] && (32'(lit[6:0]) < max_vars);
        return ok && (asg[lit[5:0]] ^ lit[7]);
    endfunction

    function automatic logic clause_unsat(input logic [CLAUSE_W-1:0] clause,
                                          input logic [ASG_W-1:0] asg,
                                          input int max_vars);
        return !(lit_true(clause, 2'd0, asg, max_vars) ||
                 lit_true(clause, 2'd1, asg, max_vars) ||
                 lit_true(clause, 2'd2, asg, max_vars));
    endfunction

    // remainder by three: base-4 digits sum, since 4 is 1 mod 3
    function automatic logic [1:0] mod3(input logic [7:0] x);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(x[1:0]) + 4'(x[3:2]) + 4'(x[5:4]) + 4'(x[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

endpackage

// ----- rtl/t3sw_cell.sv -----
module t3sw_cell #(
    parameter int W = t3sw_pkg::CLAUSE_W
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic [W-1:0] i_shift_data,
    input  logic         i_load,
    input  logic [W-1:0] i_load_data,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_clause;

    // one clause slot of the ring: rotate during a scan, write on load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_clause <= i_load_data;
        end else if (i_shift) begin
            r_clause <= i_shift_data;
        end
    end

    assign o_data = r_clause;
endmodule

// ----- rtl/t3sw_mod.sv -----
module t3sw_mod #(
    parameter int NW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [15:0]   i_dividend,
    input  logic [NW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_rem
);
    logic          r_busy;
    logic          r_done;
    logic [3:0]    r_cnt;
    logic [15:0]   r_dvd;
    logic [NW-1:0] r_rem;
    logic [NW:0]   w_trial;
    logic [NW:0]   w_next;

    // restoring remainder, one dividend bit a cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[15]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_next = w_trial - {1'b0, i_divisor};
        end else begin
            w_next = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= 4'd0;
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            r_dvd <= {r_dvd[14:0], 1'b0};
            r_rem <= w_next[NW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ----- rtl/three_sat_random_walk_step_core.sv -----
// Random-walk step engine for 3-CNF clauses. Clauses live in a ring of
// MAX_CLAUSES cells; a walk step rotates the ring once to count unsatisfied
// clauses, reduces rand_clause modulo that count, rotates it again to fetch
// the chosen clause, then flips the variable of one of its literals when
// that literal is in range. When the formula is already satisfied the step
// skips the reduction and the second rotation. The ring rotates one clause
// per cycle. Load and set words give no result. Unloaded slots inside
// clause_count read as garbage.
`include "three_sat_random_walk_step_core_assert.svh"
module three_sat_random_walk_step_core #(
    parameter int MAX_VARIABLES = t3sw_pkg::MAX_VARS_DEF,
    parameter int MAX_CLAUSES   = t3sw_pkg::MAX_CLAUSES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic         i_cfg_idx,
    input  logic [8:0]   i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // clause_index, var_a, neg_a, var_b, neg_b, var_c, neg_c,
    // init_assignment, rand_clause, rand_literal
    input  logic [119:0] i_s_tdata,
    // opcode
    input  logic [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // satisfied, unsat_count, did_flip, flipped_variable, assignment
    output logic [87:0]  o_m_tdata
);
    import t3sw_pkg::*;

    localparam int CW = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int NW = $clog2(MAX_CLAUSES + 1);
    localparam logic [ASG_W-1:0] ASG_MASK = (MAX_VARIABLES >= ASG_W) ? '1 :
        ((ASG_W'(1) << MAX_VARIABLES) - ASG_W'(1));

    t_state r_state, n_state;

    logic [6:0]    r_var_count;
    logic [8:0]    r_clause_count;
    logic [ASG_W-1:0] r_asg;
    logic [15:0]   r_rc;
    logic [7:0]    r_rl;
    logic [NW-1:0] r_checked;
    logic [CW-1:0] r_pos;
    logic [NW-1:0] r_count;
    logic [NW-1:0] r_target;
    logic [NW-1:0] r_seen;
    logic          r_found;
    logic [CLAUSE_W-1:0] r_pick;

    logic          r_res_sat, r_res_did;
    logic [5:0]    r_res_var;
    logic          r_out_valid, r_out_sat, r_out_did;
    logic [8:0]    r_out_count;
    logic [5:0]    r_out_var;
    logic [ASG_W-1:0] r_out_asg;

    logic          w_in_acc;
    logic [1:0]    w_op;
    logic [7:0]    w_cidx;
    logic [CLAUSE_W-1:0] w_ld_clause;
    logic          w_shift;
    logic          w_last;
    logic          w_in_range;
    logic          w_head_unsat;
    logic [NW-1:0] w_count_nxt;
    logic          w_div_start;
    logic          w_div_done;
    logic [NW-1:0] w_rem;
    logic          w_out_load;
    logic [CLAUSE_W-1:0] w_cell [MAX_CLAUSES];
    logic [7:0]    w_lit;
    logic          w_flip_ok;

    // input word fields
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_op        = i_s_tuser;
    assign w_cidx      = i_s_tdata[7:0];
    assign w_ld_clause = i_s_tdata[31:8];

    // clause ring, cell 0 is the head seen by the scan
    for (genvar g = 0; g < MAX_CLAUSES; g++) begin : g_cell
        t3sw_cell #(.W(CLAUSE_W)) u_cell (
            .i_clk        (i_clk),
            .i_shift      (w_shift),
            .i_shift_data (w_cell[(g + 1) % MAX_CLAUSES]),
            .i_load       (w_in_acc && w_op == OP_LOAD && 32'(w_cidx) == g),
            .i_load_data  (w_ld_clause),
            .o_data       (w_cell[g])
        );
    end

    t3sw_mod #(.NW(NW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rc),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    // scan helpers
    assign w_last       = (r_pos == CW'(MAX_CLAUSES - 1));
    assign w_in_range   = 32'(r_pos) < 32'(r_checked);
    assign w_head_unsat = clause_unsat(w_cell[0], r_asg, MAX_VARIABLES);
    assign w_count_nxt  = r_count + NW'(w_in_range && w_head_unsat);
    assign w_out_load   = !r_out_valid || i_m_tready;

    // chosen literal and flip check
    assign w_lit     = r_pick[8*mod3(r_rl) +: 8];
    assign w_flip_ok = !w_lit[6] && (32'(w_lit[6:0]) < MAX_VARIABLES) &&
                       (w_lit[6:0] < r_var_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc && w_op == OP_STEP) n_state = ST_COUNT;
            ST_COUNT: if (w_last) n_state = (w_count_nxt == '0) ? ST_OUT : ST_DIV;
            ST_DIV:   if (w_div_done) n_state = ST_PICK;
            ST_PICK:  if (w_last) n_state = ST_FLIP;
            ST_FLIP:  n_state = ST_OUT;
            ST_OUT:   if (w_out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready  = (r_state == ST_IDLE);
        w_shift     = (r_state == ST_COUNT) || (r_state == ST_PICK);
        w_div_start = (r_state == ST_COUNT) && w_last && (w_count_nxt != '0);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_var_count    <= 7'd64;
            r_clause_count <= 9'd0;
            r_asg          <= '0;
            r_out_valid    <= 1'b0;
            r_found        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_VAR_COUNT:    r_var_count    <= i_cfg_data[6:0];
                    CFG_CLAUSE_COUNT: r_clause_count <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (w_in_acc && w_op == OP_SET) begin
                r_asg <= i_s_tdata[95:32] & ASG_MASK;
            end
            if (w_in_acc && w_op == OP_STEP) begin
                r_found <= 1'b0;
            end
            if (r_state == ST_PICK && w_in_range && w_head_unsat && !r_found &&
                r_seen == r_target) begin
                r_found <= 1'b1;
            end
            if (r_state == ST_FLIP && w_flip_ok) begin
                r_asg <= r_asg ^ (ASG_W'(1) << w_lit[5:0]);
            end
            if (r_state == ST_OUT && w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // step datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_op == OP_STEP) begin
            r_rc      <= i_s_tdata[111:96];
            r_rl      <= i_s_tdata[119:112];
            r_checked <= (32'(r_clause_count) > MAX_CLAUSES) ?
                         NW'(MAX_CLAUSES) : NW'(r_clause_count);
            r_pos     <= '0;
            r_count   <= '0;
            r_seen    <= '0;
        end
        if (w_shift) begin
            r_pos <= w_last ? '0 : r_pos + CW'(1);
        end
        if (r_state == ST_COUNT) begin
            r_count <= w_count_nxt;
            if (w_last) begin
                r_res_sat <= (w_count_nxt == '0);
                r_res_did <= 1'b0;
                r_res_var <= '0;
            end
        end
        if (w_div_done) begin
            r_target <= w_rem;
        end
        if (r_state == ST_PICK && w_in_range && w_head_unsat && !r_found) begin
            if (r_seen == r_target) begin
                r_pick <= w_cell[0];
            end else begin
                r_seen <= r_seen + NW'(1);
            end
        end
        if (r_state == ST_FLIP) begin
            r_res_did <= w_flip_ok;
            r_res_var <= w_flip_ok ? w_lit[5:0] : 6'd0;
        end
        if (r_state == ST_OUT && w_out_load) begin
            r_out_sat   <= r_res_sat;
            r_out_count <= 9'(r_count);
            r_out_did   <= r_res_did;
            r_out_var   <= r_res_var;
            r_out_asg   <= r_asg;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_asg, r_out_var, r_out_did, r_out_count, r_out_sat};

    `T3SW_ASSERT_IMP(a_flip_not_sat, i_clk, i_rst_n, r_out_valid && r_out_did, !r_out_sat)
    `T3SW_ASSERT_IMP(a_seen_bound, i_clk, i_rst_n, r_state == ST_PICK, r_seen <= r_target)
    `T3SW_ASSERT_IMP(a_found_at_flip, i_clk, i_rst_n, r_state == ST_FLIP, r_found)
    `T3SW_ASSERT_NXT(a_flip_to_out, i_clk, i_rst_n, r_state == ST_FLIP, r_state == ST_OUT)
endmodule
